[hdl/assert_macros.svh]
// Assertion macros used by the RTL of the heap priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication checked in the same cycle outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// An implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/mhpq_pkg.sv]
// Package with types and constants of the heap priority queue.
`default_nettype none

package mhpq_pkg;

   localparam int REQ_DATA_W    = 32;
   localparam int REQ_USER_W    = 1;
   localparam int RSP_DATA_W    = 48;
   localparam int KEY_FIELD_W   = 32;
   localparam int COUNT_FIELD_W = 7;
   localparam int STATUS_W      = 2;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_LOAD,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_PICK,
      ST_DN_CMP,
      ST_RSP
   } state_type;

endpackage

`default_nettype wire

[hdl/max_heap_priority_queue.sv]
// Binary max-heap priority queue of signed keys with a two-port key store.
//
// Each request transaction is a push (tuser 0) or a pop of the maximum (tuser 1) and
// gives exactly one response transaction carrying the maximum, a non-empty flag, the
// count and a status. Keys live in a memory of CAPACITY entries with one write and one
// registered read port, and one signed comparator serves every key comparison of the
// sift sequencer. A push climbs from the new last position: each level reads the parent
// (UP_RD) and compares it with the key (UP_CMP), moving the parent down into the hole
// while the key is larger; the key is written where it stops. A pop moves the last entry
// to the root (POP_LOAD) and sinks it: each level reads the left child (DN_LEFT), the
// right child if present (DN_RIGHT), picks the larger (DN_PICK) and compares it with the
// key (DN_CMP). The per-level cost is set by the single read port, which fetches one
// child or parent per cycle. Overflow and underflow transactions, and a pop that empties
// the heap, go straight to the response state. The block takes no new request until the
// current one has been written to the response register, which then waits for the
// consumer while the next request is accepted; a response still held there stalls the next one in ST_RSP.
`default_nettype none

`include "assert_macros.svh"

module max_heap_priority_queue #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [mhpq_pkg::REQ_DATA_W-1:0] req_tdata,  // [31:0] key
   input  wire logic [mhpq_pkg::REQ_USER_W-1:0] req_tuser,  // [0] action
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [31:0] max_value, [32] not_empty, [39:33] count, [41:40] status, [47:42] zero
   output logic [mhpq_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   import mhpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;

   // Key store.
   logic [KEY_WIDTH-1:0] heap_mem [CAPACITY];
   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [KEY_WIDTH-1:0] mem_wd;
   logic [AW-1:0]        mem_ra;
   logic signed [KEY_WIDTH-1:0] rd_data_ff;

   state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  hole_ff, hole_in;
   logic [AW-1:0]  child_idx_ff, child_idx_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic signed [KEY_WIDTH-1:0] child_ff, child_in;
   logic signed [KEY_WIDTH-1:0] root_ff;
   status_type status_ff, status_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [KEY_FIELD_W-1:0]    rsp_max_ff;
   logic                      rsp_not_empty_ff;
   logic [COUNT_FIELD_W-1:0]  rsp_count_ff;
   status_type                rsp_status_ff;
   logic                      rsp_load;

   // Shared comparator.
   logic signed [KEY_WIDTH-1:0] cmp_a, cmp_b;
   logic                        cmp_gt;

   logic [XW-1:0] left_idx, right_idx, count_x;
   logic [AW-1:0] parent_idx;
   logic signed [KEY_WIDTH-1:0] req_key_ext;
   logic req_fire;

   assign req_key_ext = KEY_WIDTH'($signed(req_tdata[KEY_FIELD_W-1:0]));
   assign req_fire    = req_tvalid && req_tready;
   assign req_tready  = (state_ff == ST_IDLE);

   assign left_idx   = {1'b0, hole_ff, 1'b1};
   assign right_idx  = {1'b0, hole_ff, 1'b0} + XW'(2);
   assign count_x    = XW'(count_ff);
   assign parent_idx = (hole_ff - AW'(1)) >> 1;

   assign cmp_gt = cmp_a > cmp_b;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         heap_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= heap_mem[mem_ra];
   end

   // The root is mirrored in a register so the maximum is always at hand.
   always_ff @(posedge clock) begin
      if (mem_we && (mem_wa == '0)) begin
         root_ff <= mem_wd;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      hole_in      = hole_ff;
      child_idx_in = child_idx_ff;
      key_in       = key_ff;
      child_in     = child_ff;
      status_in    = status_ff;
      mem_we       = 1'b0;
      mem_wa       = hole_ff;
      mem_wd       = key_ff;
      mem_ra       = '0;
      cmp_a        = key_ff;
      cmp_b        = rd_data_ff;
      rsp_load     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // The last entry is fetched speculatively in case this is a pop.
            mem_ra = AW'(count_ff - CW'(1));
            if (req_fire) begin
               status_in = STATUS_OK;
               if (req_tuser[0] == ACT_PUSH) begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     status_in = STATUS_OVERFLOW;
                     state_in  = ST_RSP;
                  end else begin
                     key_in   = req_key_ext;
                     hole_in  = AW'(count_ff);
                     count_in = count_ff + CW'(1);
                     state_in = ST_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_UNDERFLOW;
                     state_in  = ST_RSP;
                  end else begin
                     count_in = count_ff - CW'(1);
                     state_in = (count_ff == CW'(1)) ? ST_RSP : ST_POP_LOAD;
                  end
               end
            end
         end
         ST_UP_RD: begin
            if (hole_ff == '0) begin
               mem_we   = 1'b1;
               state_in = ST_RSP;
            end else begin
               mem_ra   = parent_idx;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            // The parent moves down into the hole while the new key is larger.
            mem_we = 1'b1;
            if (cmp_gt) begin
               mem_wd   = rd_data_ff;
               hole_in  = parent_idx;
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_RSP;
            end
         end
         ST_POP_LOAD: begin
            key_in   = rd_data_ff;
            hole_in  = '0;
            state_in = ST_DN_LEFT;
         end
         ST_DN_LEFT: begin
            if (left_idx >= count_x) begin
               mem_we   = 1'b1;
               state_in = ST_RSP;
            end else begin
               mem_ra   = left_idx[AW-1:0];
               state_in = ST_DN_RIGHT;
            end
         end
         ST_DN_RIGHT: begin
            child_in     = rd_data_ff;
            child_idx_in = left_idx[AW-1:0];
            if (right_idx < count_x) begin
               mem_ra   = right_idx[AW-1:0];
               state_in = ST_DN_PICK;
            end else begin
               state_in = ST_DN_CMP;
            end
         end
         ST_DN_PICK: begin
            // Equal children keep the left one.
            cmp_a = rd_data_ff;
            cmp_b = child_ff;
            if (cmp_gt) begin
               child_in     = rd_data_ff;
               child_idx_in = right_idx[AW-1:0];
            end
            state_in = ST_DN_CMP;
         end
         ST_DN_CMP: begin
            cmp_a  = child_ff;
            cmp_b  = key_ff;
            mem_we = 1'b1;
            if (cmp_gt) begin
               mem_wd   = child_ff;
               hole_in  = child_idx_ff;
               state_in = ST_DN_LEFT;
            end else begin
               state_in = ST_RSP;
            end
         end
         ST_RSP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hole_ff      <= hole_in;
      child_idx_ff <= child_idx_in;
      key_ff       <= key_in;
      child_ff     <= child_in;
      status_ff    <= status_in;
      if (rsp_load) begin
         rsp_max_ff       <= (count_ff != '0) ? KEY_FIELD_W'($unsigned(root_ff)) : '0;
         rsp_not_empty_ff <= (count_ff != '0);
         rsp_count_ff     <= COUNT_FIELD_W'(count_ff);
         rsp_status_ff    <= status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - KEY_FIELD_W - 1 - COUNT_FIELD_W - STATUS_W)'(0),
                        rsp_status_ff, rsp_count_ff, rsp_not_empty_ff, rsp_max_ff};

   `ASSERT_ALWAYS(a_count_in_range, count_ff <= CW'(CAPACITY), "heap count beyond capacity")
   `ASSERT_IMPLIES(a_write_in_heap, mem_we, XW'(mem_wa) < count_x, "write outside the heap")
   `ASSERT_IMPLIES(a_hole_in_heap, state_ff == ST_UP_RD || state_ff == ST_DN_LEFT,
                   XW'(hole_ff) < count_x, "sift position outside the heap")
   `ASSERT_IMPLIES(a_overflow_full, rsp_load && status_ff == STATUS_OVERFLOW,
                   count_ff == CW'(CAPACITY), "overflow reported on a heap that is not full")
   `ASSERT_NEXT(a_load_shows, rsp_load, rsp_valid_ff, "loaded response not presented")

endmodule

`default_nettype wire
